// ===== sv/assert_macros.svh =====
// Assertion macros used by the page replacement datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ECPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define ECPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ecpr_pkg.sv =====
// Shared command and status types for the clock page replacement block.
package ecpr_pkg;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture request word, run tag compare
      logic hit_done;  // update hit frame bits, post hit response
      logic step;      // age frame under hand, advance hand
      logic replace;   // load page into frame under hand, post miss response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic any_hit;     // some frame matched the captured page
      logic hand_clear;  // frame under hand has access and modify clear
      logic out_free;    // response register can take a word this cycle
   } status_type;

endpackage

// ===== sv/ecpr_ctrl.sv =====
// Controller state machine: lookup, sweep and response sequencing.
module ecpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ecpr_pkg::status_type status,
   output ecpr_pkg::cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RESOLVE = 2'd1;
   localparam logic [1:0] ST_SWEEP   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (status.any_hit) begin
               if (status.out_free) begin
                  cmd.hit_done = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (status.hand_clear) begin
               if (status.out_free) begin
                  cmd.replace = 1'b1;
                  state_in    = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/ecpr_datapath.sv =====
// Frame table, clock hand, sweep update and response register.
`include "assert_macros.svh"

module ecpr_datapath #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [PAGE_BITS-1:0]         req_page_number,
   input  logic                         req_op,
   input  ecpr_pkg::cmd_type            cmd,
   output ecpr_pkg::status_type         status,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [$clog2(FRAMES)-1:0]    rsp_frame_index,
   output logic [PAGE_BITS-1:0]         rsp_evicted_page,
   output logic [FRAMES-1:0]            rsp_writeback_mask
);

   localparam int IW = $clog2(FRAMES);
   localparam logic [IW-1:0] LAST = IW'(FRAMES - 1);

   logic [PAGE_BITS-1:0] tags_ff [FRAMES];
   logic [PAGE_BITS-1:0] tags_in [FRAMES];
   logic [FRAMES-1:0]    acc_ff, acc_in;
   logic [FRAMES-1:0]    mod_ff, mod_in;
   logic [IW-1:0]        hand_ff, hand_in;
   logic [FRAMES-1:0]    match_ff, match_in;
   logic [FRAMES-1:0]    wb_ff, wb_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 wr_ff, wr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [IW-1:0]        rsp_frame_ff, rsp_frame_in;
   logic [PAGE_BITS-1:0] rsp_evicted_ff, rsp_evicted_in;
   logic [FRAMES-1:0]    rsp_mask_ff, rsp_mask_in;

   logic [IW-1:0]        hit_idx;
   logic [IW-1:0]        hand_inc;
   logic                 out_free;

   // lowest matching frame wins
   always_comb begin
      hit_idx = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_idx = IW'(i);
      end
   end

   assign hand_inc = (hand_ff == LAST) ? '0 : hand_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign status.any_hit    = |match_ff;
   assign status.hand_clear = !acc_ff[hand_ff] && !mod_ff[hand_ff];
   assign status.out_free   = out_free;

   always_comb begin
      tags_in        = tags_ff;
      acc_in         = acc_ff;
      mod_in         = mod_ff;
      hand_in        = hand_ff;
      match_in       = match_ff;
      wb_in          = wb_ff;
      page_in        = page_ff;
      wr_in          = wr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_hit_in     = rsp_hit_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_mask_in    = rsp_mask_ff;

      if (cmd.load) begin
         page_in = req_page_number;
         wr_in   = req_op;
         wb_in   = '0;
         for (int i = 0; i < FRAMES; i++) begin
            match_in[i] = (tags_ff[i] == req_page_number);
         end
      end

      if (cmd.hit_done) begin
         acc_in[hit_idx] = 1'b1;
         if (wr_ff) mod_in[hit_idx] = 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_hit_in     = 1'b1;
         rsp_frame_in   = hit_idx;
         rsp_evicted_in = page_ff;
         rsp_mask_in    = '0;
      end

      // second chance: A1M1 keeps M, otherwise clear; dirty clear = write-back
      if (cmd.step) begin
         if (!(acc_ff[hand_ff] && mod_ff[hand_ff])) begin
            if (mod_ff[hand_ff]) wb_in[hand_ff] = 1'b1;
            mod_in[hand_ff] = 1'b0;
         end
         acc_in[hand_ff] = 1'b0;
         hand_in         = hand_inc;
      end

      if (cmd.replace) begin
         tags_in[hand_ff] = page_ff;
         hand_in          = hand_inc;
         rsp_valid_in     = 1'b1;
         rsp_hit_in       = 1'b0;
         rsp_frame_in     = hand_ff;
         rsp_evicted_in   = tags_ff[hand_ff];
         rsp_mask_in      = wb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            tags_ff[i] <= PAGE_BITS'(i);
         end
         acc_ff       <= '0;
         mod_ff       <= '0;
         hand_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tags_ff      <= tags_in;
         acc_ff       <= acc_in;
         mod_ff       <= mod_in;
         hand_ff      <= hand_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff       <= match_in;
      wb_ff          <= wb_in;
      page_ff        <= page_in;
      wr_ff          <= wr_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_mask_ff    <= rsp_mask_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_frame_index    = rsp_frame_ff;
   assign rsp_evicted_page   = rsp_evicted_ff;
   assign rsp_writeback_mask = rsp_mask_ff;

   `ECPR_ASSERT_NOW(a_hand_range, 1'b1, hand_ff <= LAST, "clock hand out of range")
   `ECPR_ASSERT_NOW(a_replace_clear, cmd.replace, status.hand_clear, "replace of used frame")
   `ECPR_ASSERT_NEXT(a_replace_adv, cmd.replace, hand_ff != $past(hand_ff), "hand did not move")
   `ECPR_ASSERT_NOW(a_post_free, cmd.hit_done || cmd.replace, out_free, "response overwritten")

endmodule

// ===== sv/enhanced_clock_page_replacement.sv =====
// Top level of the enhanced second-chance clock page replacement block.
// Each request word is one page access (page number, op: 0 read, 1 write)
// and yields exactly one response word: hit flag, frame index, evicted page
// (the request page on a hit) and a per-frame write-back mask. The frame
// tags are compared in parallel in the cycle the request is accepted; a hit
// resolves from the registered match in the resolve state once the output
// register is free. A miss goes from the resolve state into the sweep, then
// moves the clock hand one frame per cycle, aging access/modify bits, until
// it lands on a frame with both bits clear, passing over at most 2 * FRAMES
// frames. The hand sweep is what sets miss latency. Items are handled one
// at a time; the next request word is taken the cycle after a response
// lands in the output register, while that response may still wait for
// rsp_ready. A response still held in the output register stalls the next
// one until rsp_ready takes it. After reset frame i holds page i with both
// bits clear and the hand at frame 0.
module enhanced_clock_page_replacement #(
   parameter int FRAMES    = 4,
   parameter int PAGE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [PAGE_BITS-1:0]      req_page_number,
   input  logic                      req_op,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic [$clog2(FRAMES)-1:0] rsp_frame_index,
   output logic [PAGE_BITS-1:0]      rsp_evicted_page,
   output logic [FRAMES-1:0]         rsp_writeback_mask
);

   ecpr_pkg::cmd_type    cmd;
   ecpr_pkg::status_type status;

   // sequencing: idle, resolve lookup, sweep
   ecpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // frame table, hand and response register
   ecpr_datapath #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_page_number    (req_page_number),
      .req_op             (req_op),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_writeback_mask (rsp_writeback_mask)
   );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the enhanced second-chance clock page replacement block.
module tb_top;

   localparam int FRAMES         = 4;
   localparam int PAGE_BITS      = 16;
   localparam int FIDX_BITS      = $clog2(FRAMES);
   localparam int CLK_PERIOD     = 12;
   localparam int RANDOM_WORDS   = 1530;
   // Worst miss: a sweep over 2 * FRAMES frames, plus output register; pad generously.
   localparam int DRAIN_CYCLES   = 4 * FRAMES + 16;
   // ~1550 words, each slowed by sender gap, sweep and receiver stall; wide margin.
   localparam int TIMEOUT_CYCLES = 800_000;

   // Access kind carried on req_op.
   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } access_op_type;

   // One expected response word.
   typedef struct packed {
      logic                 hit;
      logic [FIDX_BITS-1:0] frame;
      logic [PAGE_BITS-1:0] evicted;
      logic [FRAMES-1:0]    wb_mask;
   } access_outcome_type;

   // One row of the directed sequence; want is used only when typed is set.
   typedef struct {
      logic [PAGE_BITS-1:0] page;
      access_op_type        op;
      bit                   typed;
      access_outcome_type   want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [PAGE_BITS-1:0]   req_page_number;
   logic                   req_op;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_hit;
   logic [FIDX_BITS-1:0]   rsp_frame_index;
   logic [PAGE_BITS-1:0]   rsp_evicted_page;
   logic [FRAMES-1:0]      rsp_writeback_mask;

   // Predictor copy of the frame table and clock hand.
   logic [PAGE_BITS-1:0]   frame_tag   [FRAMES];
   logic                   frame_ref   [FRAMES];
   logic                   frame_dirty [FRAMES];
   int unsigned            model_hand;

   access_outcome_type     pending_outcomes [$];
   int                     mismatch_count = 0;
   bit                     back_to_back;

   // Directed sequence, starting from reset (frame i holds page i, bits clear, hand 0).
   // Rows with typed set carry a hand-computed response; the rest go through the predictor.
   stim_row_type directed_rows [21] = '{
      // plain read hit on a reset page, then write hit on the top frame
      '{16'h0000, OP_READ,  1'b1, '{1'b1, 2'd0, 16'h0000, 4'h0}},
      '{16'h0003, OP_WRITE, 1'b1, '{1'b1, 2'd3, 16'h0003, 4'h0}},
      // miss at all-ones page: frame 0 is aged, frame 1 taken
      '{16'hFFFF, OP_READ,  1'b1, '{1'b0, 2'd1, 16'h0001, 4'h0}},
      // freshly loaded page hits with clear bits; write marks it
      '{16'hFFFF, OP_WRITE, 1'b1, '{1'b1, 2'd1, 16'hFFFF, 4'h0}},
      // write miss: the loaded page must stay clean
      '{16'h8000, OP_WRITE, 1'b1, '{1'b0, 2'd2, 16'h0002, 4'h0}},
      // make every frame referenced and dirty
      '{16'h0000, OP_WRITE, 1'b0, '0},
      '{16'h8000, OP_WRITE, 1'b0, '0},
      // longest sweep: two full turns, every frame written back
      '{16'h1234, OP_READ,  1'b1, '{1'b0, 2'd3, 16'h0003, 4'hF}},
      '{16'h1234, OP_WRITE, 1'b0, '0},
      '{16'h5555, OP_READ,  1'b0, '0},
      '{16'hAAAA, OP_WRITE, 1'b0, '0},
      '{16'h8000, OP_READ,  1'b0, '0},
      '{16'h7FFF, OP_WRITE, 1'b0, '0},
      '{16'h0001, OP_READ,  1'b0, '0},
      '{16'h7FFF, OP_WRITE, 1'b0, '0},
      '{16'h0002, OP_READ,  1'b0, '0},
      // single dirty write-back mixed with a demotion
      '{16'h0003, OP_READ,  1'b0, '0},
      '{16'h0FF0, OP_WRITE, 1'b0, '0},
      '{16'hF00F, OP_READ,  1'b0, '0},
      '{16'h0000, OP_WRITE, 1'b0, '0},
      '{16'h0001, OP_READ,  1'b0, '0}
   };

   enhanced_clock_page_replacement #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_page_number    (req_page_number),
      .req_op             (req_op),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_frame_index    (rsp_frame_index),
      .rsp_evicted_page   (rsp_evicted_page),
      .rsp_writeback_mask (rsp_writeback_mask)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Predictor: applies one page access to the table copy, returns the response word.
   function automatic access_outcome_type resolve_access(input logic [PAGE_BITS-1:0] page,
                                                         input access_op_type op);
      access_outcome_type res;
      int                 hit_frame;
      int unsigned        sweep;
      res       = '0;
      hit_frame = -1;
      // scan downward so the lowest matching frame wins
      for (int f = FRAMES - 1; f >= 0; f--) begin
         if (frame_tag[f] == page) hit_frame = f;
      end
      if (hit_frame >= 0) begin
         frame_ref[hit_frame] = 1'b1;
         if (op == OP_WRITE) frame_dirty[hit_frame] = 1'b1;
         res.hit     = 1'b1;
         res.frame   = FIDX_BITS'(hit_frame);
         res.evicted = page;
         return res;
      end
      // sweep: ref+dirty demotes to dirty only; anything else is cleared,
      // dirty-only frames get written back
      for (sweep = 0; sweep < 2 * FRAMES + 1; sweep++) begin
         if (!frame_ref[model_hand] && !frame_dirty[model_hand]) break;
         if (!(frame_ref[model_hand] && frame_dirty[model_hand])) begin
            if (frame_dirty[model_hand]) res.wb_mask[model_hand] = 1'b1;
            frame_dirty[model_hand] = 1'b0;
         end
         frame_ref[model_hand] = 1'b0;
         model_hand = (model_hand + 1) % FRAMES;
      end
      // victim keeps clear bits, even on a write
      res.frame                = FIDX_BITS'(model_hand);
      res.evicted              = frame_tag[model_hand];
      frame_tag[model_hand]    = page;
      model_hand               = (model_hand + 1) % FRAMES;
      return res;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
   endfunction

   // Drives one request word from a falling edge, waits for the handshake,
   // queues the expected response, and returns on the following falling edge.
   task automatic send_access(input logic [PAGE_BITS-1:0] page, input access_op_type op,
                              input bit typed, input access_outcome_type want);
      int unsigned        gap;
      int unsigned        roll;
      access_outcome_type outcome;
      roll = $urandom_range(0, 99);
      if (back_to_back || roll < 55) gap = 0;
      else if (roll < 90)            gap = $urandom_range(1, 3);
      else                           gap = $urandom_range(8, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // valid held with a stable payload until taken
      req_valid       <= 1'b1;
      req_page_number <= page;
      req_op          <= op;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outcome = resolve_access(page, op);
      if (typed) outcome = want;
      pending_outcomes.push_back(outcome);
      @(negedge clock);
   endtask

   // Response checker: every accepted word against the oldest expectation.
   always @(posedge clock) begin
      access_outcome_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            note_mismatch($sformatf("unexpected word hit=%0d frame=%0d evicted=%h wb=%b",
                                    rsp_hit, rsp_frame_index, rsp_evicted_page,
                                    rsp_writeback_mask));
         end else begin
            exp_word = pending_outcomes.pop_front();
            if (rsp_hit !== exp_word.hit)
               note_mismatch($sformatf("hit exp %0d got %0d", exp_word.hit, rsp_hit));
            if (rsp_frame_index !== exp_word.frame)
               note_mismatch($sformatf("frame_index exp %0d got %0d",
                                       exp_word.frame, rsp_frame_index));
            if (rsp_evicted_page !== exp_word.evicted)
               note_mismatch($sformatf("evicted_page exp %h got %h",
                                       exp_word.evicted, rsp_evicted_page));
            if (rsp_writeback_mask !== exp_word.wb_mask)
               note_mismatch($sformatf("writeback_mask exp %b got %b",
                                       exp_word.wb_mask, rsp_writeback_mask));
         end
      end
   end

   // Receiver back-pressure: long ready stretches, short and occasional long stalls.
   initial begin
      int unsigned hold;
      int unsigned roll;
      hold = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(50, 200);
            end else if (roll < 60) begin
               rsp_ready <= 1'b1;
               hold = $urandom_range(1, 8);
            end else if (roll < 92) begin
               rsp_ready <= 1'b0;
               hold = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               hold = $urandom_range(10, 30);
            end
         end
         hold--;
      end
   end

   // Main sequence: reset, directed table, random traffic, drain, verdict.
   initial begin
      access_outcome_type   none;
      logic [PAGE_BITS-1:0] hot_base;
      logic [PAGE_BITS-1:0] page;
      int unsigned          roll;
      access_op_type        op;
      none     = '0;
      hot_base = '0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_page_number <= '0;
      req_op          <= OP_READ;
      back_to_back     = 1'b0;
      // predictor reset state
      for (int f = 0; f < FRAMES; f++) begin
         frame_tag[f]   = PAGE_BITS'(f);
         frame_ref[f]   = 1'b0;
         frame_dirty[f] = 1'b0;
      end
      model_hand = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_access(directed_rows[r].page, directed_rows[r].op,
                     directed_rows[r].typed, directed_rows[r].want);

      // Random part: mostly a hot set of six pages over four frames so hits,
      // aging and write-backs all stay busy; the rest low pages and wide noise.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 120 == 0) hot_base = PAGE_BITS'($urandom);
         // every fourth window of 150 words runs with no sender gaps
         back_to_back = ((n / 150) % 4 == 2);
         roll = $urandom_range(0, 99);
         if (roll < 75)      page = hot_base + PAGE_BITS'($urandom_range(0, 5));
         else if (roll < 85) page = PAGE_BITS'($urandom_range(0, 7));
         else                page = PAGE_BITS'($urandom);
         op = access_op_type'($urandom_range(0, 1));
         send_access(page, op, 1'b0, none);
      end
      req_valid <= 1'b0;

      // drain, then keep clocking for DRAIN_CYCLES to catch stray words
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hang guard.
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ecpr_pkg.sv
sv/ecpr_ctrl.sv
sv/ecpr_datapath.sv
sv/enhanced_clock_page_replacement.sv
dv/tb_top.sv
